// ----- src/pidl_pkg.sv -----
// ----------------------------------------------------------------------------
// pidl_pkg
// Types and constants shared by the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidl_pkg;

    localparam int KIND_W  = 2;
    localparam int POS_W   = 7;
    localparam int ELEM_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } t_cell_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    typedef struct packed {
        t_cell_op                  op;
        logic [POS_W-1:0]          pos;
        logic [COUNT_W-1:0]        count_m1;
        logic signed [ELEM_W-1:0]  elem;
    } t_cell_ctrl;

endpackage

// ----- src/pidl_in_if.sv -----
// ----------------------------------------------------------------------------
// pidl_in_if
// Operation channel: valid/ready handshake with kind, position and element.
// ----------------------------------------------------------------------------
interface pidl_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [pidl_pkg::KIND_W-1:0]             kind;
    logic [pidl_pkg::POS_W-1:0]              position;
    logic signed [pidl_pkg::ELEM_W-1:0]      element;

    modport source (output valid, output kind, output position, output element,
                    input ready);
    modport sink   (input valid, input kind, input position, input element,
                    output ready);
endinterface

// ----- src/pidl_out_if.sv -----
// ----------------------------------------------------------------------------
// pidl_out_if
// Result channel: valid/ready handshake with status, value, count and last.
// ----------------------------------------------------------------------------
interface pidl_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [pidl_pkg::STAT_W-1:0]             status;
    logic signed [pidl_pkg::ELEM_W-1:0]      value;
    logic [pidl_pkg::COUNT_W-1:0]            count;
    logic                                    last;

    modport source (output valid, output status, output value, output count,
                    output last, input ready);
    modport sink   (input valid, input status, input value, input count,
                    input last, output ready);
endinterface

// ----- src/pidl_cell.sv -----
// ----------------------------------------------------------------------------
// pidl_cell
// One list slot: holds a word and on shifts takes it from a neighbor, the new element or the head cell.
// ----------------------------------------------------------------------------
module pidl_cell #(
    parameter int IDX = 0
) (
    input  logic                               i_clk,
    input  pidl_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [pidl_pkg::ELEM_W-1:0] i_left,
    input  logic signed [pidl_pkg::ELEM_W-1:0] i_right,
    input  logic signed [pidl_pkg::ELEM_W-1:0] i_head,
    output logic signed [pidl_pkg::ELEM_W-1:0] o_data
);

    localparam logic [pidl_pkg::POS_W-1:0] IDX_P = pidl_pkg::POS_W'(IDX);

    logic signed [pidl_pkg::ELEM_W-1:0] r_data;
    logic signed [pidl_pkg::ELEM_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            pidl_pkg::OP_INSERT: begin
                if (IDX_P == i_ctrl.pos) begin
                    n_data = i_ctrl.elem;
                end else if (IDX_P > i_ctrl.pos) begin
                    n_data = i_left;
                end
            end
            pidl_pkg::OP_DELETE: begin
                if (IDX_P >= i_ctrl.pos) begin
                    n_data = i_right;
                end
            end
            pidl_pkg::OP_ROTATE: begin
                if (IDX_P == i_ctrl.count_m1) begin
                    n_data = i_head;
                end else if (IDX_P < i_ctrl.count_m1) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- src/positional_insert_delete_list.sv -----
// Insert and delete: the result is registered in the cycle after acceptance.
// Read-out of n entries: after the move to the read state, one word per cycle
// from the head cell while the row rotates, held while the output stalls; no
// new word is taken until the last leaves. Throughput: one insert or delete
// per cycle while the output is not stalled. Reset (synchronous, active low)
// clears the count, state and output valid; the cell words are not reset.
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list of signed words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
module positional_insert_delete_list #(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pidl_in_if.sink             i_in,
    pidl_out_if.source          o_out
);

    localparam logic [pidl_pkg::COUNT_W-1:0] DEPTH_C = pidl_pkg::COUNT_W'(DEPTH);

    pidl_pkg::t_state                     r_state, n_state;
    logic [pidl_pkg::COUNT_W-1:0]         r_count, n_count;
    logic [pidl_pkg::COUNT_W-1:0]         r_idx, n_idx;
    logic                                 r_out_valid, n_out_valid;
    pidl_pkg::t_status                    r_out_status, n_out_status;
    logic signed [pidl_pkg::ELEM_W-1:0]   r_out_value, n_out_value;
    logic [pidl_pkg::COUNT_W-1:0]         r_out_count, n_out_count;
    logic                                 r_out_last, n_out_last;

    pidl_pkg::t_cell_ctrl                 w_ctrl;
    logic signed [pidl_pkg::ELEM_W-1:0]   w_data [DEPTH];
    logic signed [pidl_pkg::ELEM_W-1:0]   w_sel;
    logic                                 w_slot_free;
    logic                                 w_accept;

    // cell row
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [pidl_pkg::ELEM_W-1:0] w_left;
            logic signed [pidl_pkg::ELEM_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_end
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            pidl_cell #(.IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_left  (w_left),
                .i_right (w_right),
                .i_head  (w_data[0]),
                .o_data  (w_data[g])
            );
        end
    endgenerate

    // word at the delete position
    always_comb begin
        w_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (pidl_pkg::POS_W'(i) == i_in.position) begin
                w_sel = w_sel | w_data[i];
            end
        end
    end

    assign w_slot_free = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == pidl_pkg::ST_IDLE) && w_slot_free;
    assign w_accept    = i_in.valid && i_in.ready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        w_ctrl.op       = pidl_pkg::OP_HOLD;
        w_ctrl.pos      = i_in.position;
        w_ctrl.count_m1 = r_count - 7'd1;
        w_ctrl.elem     = i_in.element;

        case (r_state)
            pidl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid  = 1'b1;
                    n_out_status = pidl_pkg::STAT_OK;
                    n_out_value  = '0;
                    n_out_count  = r_count;
                    n_out_last   = 1'b1;
                    case (pidl_pkg::t_kind'(i_in.kind))
                        pidl_pkg::KIND_INSERT: begin
                            if (r_count >= DEPTH_C) begin
                                n_out_status = pidl_pkg::STAT_FULL;
                            end else if (i_in.position > r_count) begin
                                n_out_status = pidl_pkg::STAT_BADPOS;
                            end else begin
                                w_ctrl.op   = pidl_pkg::OP_INSERT;
                                n_count     = r_count + 7'd1;
                                n_out_value = i_in.element;
                                n_out_count = r_count + 7'd1;
                            end
                        end
                        pidl_pkg::KIND_DELETE: begin
                            if (r_count == '0) begin
                                n_out_status = pidl_pkg::STAT_EMPTY;
                            end else if (i_in.position >= r_count) begin
                                n_out_status = pidl_pkg::STAT_BADPOS;
                            end else begin
                                w_ctrl.op   = pidl_pkg::OP_DELETE;
                                n_count     = r_count - 7'd1;
                                n_out_value = w_sel;
                                n_out_count = r_count - 7'd1;
                            end
                        end
                        pidl_pkg::KIND_READ: begin
                            if (r_count == '0) begin
                                n_out_status = pidl_pkg::STAT_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && !o_out.ready;
                                n_idx       = '0;
                                n_state     = pidl_pkg::ST_READ;
                            end
                        end
                        default: begin
                            n_out_status = pidl_pkg::STAT_BADPOS;
                        end
                    endcase
                end
            end
            pidl_pkg::ST_READ: begin
                if (w_slot_free) begin
                    w_ctrl.op    = pidl_pkg::OP_ROTATE;
                    n_out_valid  = 1'b1;
                    n_out_status = pidl_pkg::STAT_OK;
                    n_out_value  = w_data[0];
                    n_out_count  = r_count;
                    n_out_last   = (r_idx == w_ctrl.count_m1);
                    n_idx        = r_idx + 7'd1;
                    if (r_idx == w_ctrl.count_m1) begin
                        n_state = pidl_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = pidl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pidl_pkg::ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.value  = r_out_value;
    assign o_out.count  = r_out_count;
    assign o_out.last   = r_out_last;

endmodule
